// ===== rtl/core/i2cm_pkg.sv =====
// Shared types, codes and reset constants of the I2C master byte controller.
package i2cm_pkg;

    localparam int unsigned DELAY_WIDTH_DEF = 16;
    localparam int unsigned CFG_DATA_W      = 16;
    localparam int unsigned CFG_ADDR_W      = 2;

    // Request codes on req_type.
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_TIME  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_TIME = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAST_MODE = 2'd2;

    localparam logic [15:0] LOW_TIME_RST  = 16'd50;
    localparam logic [15:0] HIGH_TIME_RST = 16'd40;
    localparam logic        FAST_MODE_RST = 1'b0;

    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;
    localparam logic [3:0] BITS_BYTE  = 4'd8;
    localparam logic [3:0] BITS_ACK   = 4'd1;

    typedef enum logic [10:0] {
        PH_IDLE     = 11'b000_0000_0001,
        PH_ST_WAIT  = 11'b000_0000_0010,
        PH_ST_SETUP = 11'b000_0000_0100,
        PH_ST_HOLD  = 11'b000_0000_1000,
        PH_SP_WAIT  = 11'b000_0001_0000,
        PH_SP_HOLD  = 11'b000_0010_0000,
        PH_SP_TAIL  = 11'b000_0100_0000,
        PH_BIT_LOW  = 11'b000_1000_0000,
        PH_BIT_WAIT = 11'b001_0000_0000,
        PH_BIT_HIGH = 11'b010_0000_0000,
        PH_BIT_END  = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic [15:0] low_time;
        logic [15:0] high_time;
        logic        fast_mode;
    } cfg_t;

    // Controller state apart from the delay counter, whose width is a parameter.
    typedef struct packed {
        phase_t      phase;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic        scl_drive;
        logic        sda_drive;
        logic        nack_pending;
        logic        ack_flag;
        logic        sda_enable;
        logic        op_read;
        logic        ack_stage;
        logic        sampled;
        logic [7:0]  rx_byte;
        logic [7:0]  read_reg;
    } state_t;

    localparam state_t STATE_RST = '{
        phase:        PH_IDLE,
        bit_count:    4'd0,
        shift_byte:   BYTE_ONES,
        scl_drive:    1'b0,
        sda_drive:    1'b0,
        nack_pending: 1'b0,
        ack_flag:     1'b0,
        sda_enable:   1'b0,
        op_read:      1'b0,
        ack_stage:    1'b0,
        sampled:      1'b0,
        rx_byte:      BYTE_ZEROS,
        read_reg:     BYTE_ZEROS
    };

endpackage

// ===== rtl/core/i2cm_cfg.sv =====
// Configuration register file: bus timing and fast mode setting.
module i2cm_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output i2cm_pkg::cfg_t                       cfg
);

    i2cm_pkg::cfg_t cfg_reg;
    i2cm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_addr)
                i2cm_pkg::CFG_LOW_TIME:  cfg_next.low_time  = cfg_wdata;
                i2cm_pkg::CFG_HIGH_TIME: cfg_next.high_time = cfg_wdata;
                i2cm_pkg::CFG_FAST_MODE: cfg_next.fast_mode = cfg_wdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_time  <= i2cm_pkg::LOW_TIME_RST;
            cfg_reg.high_time <= i2cm_pkg::HIGH_TIME_RST;
            cfg_reg.fast_mode <= i2cm_pkg::FAST_MODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/i2cm_step.sv =====
// Next-state logic of the bus master for one tick of the timing base.
module i2cm_step #(
    parameter int unsigned DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
    input  i2cm_pkg::state_t        st,
    input  logic [DELAY_WIDTH-1:0]  delay_count,
    input  i2cm_pkg::cfg_t          cfg,
    input  logic [2:0]              req_type,
    input  logic [7:0]              write_data,
    input  logic                    read_last,
    input  logic                    scl_in,
    input  logic                    sda_in,
    output i2cm_pkg::state_t        st_next,
    output logic [DELAY_WIDTH-1:0]  delay_next,
    output logic                    done
);

    logic [DELAY_WIDTH-1:0] low_ld;
    logic [DELAY_WIDTH-1:0] high_ld;
    logic [DELAY_WIDTH-1:0] dly_dec;
    logic                   dly_end;
    logic [3:0]             bits_left;
    logic                   in_bit;
    i2cm_pkg::state_t       nx;
    logic [DELAY_WIDTH-1:0] dnx;
    logic                   dn;

    assign low_ld  = DELAY_WIDTH'(cfg.low_time);
    assign high_ld = DELAY_WIDTH'(cfg.high_time);

    // A delay of zero ends on its first tick, as one of one does.
    assign dly_end   = (delay_count <= DELAY_WIDTH'(1));
    assign dly_dec   = dly_end ? '0 : delay_count - DELAY_WIDTH'(1);
    assign bits_left = st.bit_count - 4'd1;

    always_comb
    begin
        nx  = st;
        dnx = delay_count;
        dn  = 1'b0;
        unique case (st.phase)
            i2cm_pkg::PH_IDLE:
            begin
                if (req_type == i2cm_pkg::REQ_START)
                begin
                    nx.scl_drive = 1'b0;
                    nx.phase     = i2cm_pkg::PH_ST_WAIT;
                end
                else if (req_type == i2cm_pkg::REQ_STOP)
                begin
                    nx.sda_drive = 1'b1;
                    nx.scl_drive = 1'b0;
                    nx.phase     = i2cm_pkg::PH_SP_WAIT;
                end
                else if (req_type == i2cm_pkg::REQ_WRITE || req_type == i2cm_pkg::REQ_READ)
                begin
                    nx.op_read      = (req_type == i2cm_pkg::REQ_READ);
                    nx.nack_pending = read_last;
                    nx.ack_stage    = 1'b0;
                    nx.scl_drive    = 1'b1;
                    nx.shift_byte   = (req_type == i2cm_pkg::REQ_READ) ?
                                      i2cm_pkg::BYTE_ONES : write_data;
                    nx.sda_enable   = (req_type != i2cm_pkg::REQ_READ);
                    nx.bit_count    = i2cm_pkg::BITS_BYTE;
                    dnx             = low_ld;
                    nx.phase        = i2cm_pkg::PH_BIT_LOW;
                end
            end
            i2cm_pkg::PH_ST_WAIT:
            begin
                if (scl_in)
                begin
                    dnx      = cfg.fast_mode ? high_ld : low_ld;
                    nx.phase = i2cm_pkg::PH_ST_SETUP;
                end
            end
            i2cm_pkg::PH_ST_SETUP:
            begin
                dnx = dly_dec;
                if (dly_end)
                begin
                    nx.sda_drive = 1'b1;
                    dnx          = high_ld;
                    nx.phase     = i2cm_pkg::PH_ST_HOLD;
                end
            end
            i2cm_pkg::PH_ST_HOLD:
            begin
                dnx = dly_dec;
                if (dly_end)
                begin
                    nx.scl_drive = 1'b1;
                    nx.sda_drive = 1'b0;
                    dn           = 1'b1;
                    nx.phase     = i2cm_pkg::PH_IDLE;
                end
            end
            i2cm_pkg::PH_SP_WAIT:
            begin
                if (scl_in)
                begin
                    dnx      = high_ld;
                    nx.phase = i2cm_pkg::PH_SP_HOLD;
                end
            end
            i2cm_pkg::PH_SP_HOLD:
            begin
                dnx = dly_dec;
                if (dly_end)
                begin
                    nx.sda_drive = 1'b0;
                    dnx          = low_ld;
                    nx.phase     = i2cm_pkg::PH_SP_TAIL;
                end
            end
            i2cm_pkg::PH_SP_TAIL:
            begin
                dnx = dly_dec;
                if (dly_end)
                begin
                    dn       = 1'b1;
                    nx.phase = i2cm_pkg::PH_IDLE;
                end
            end
            i2cm_pkg::PH_BIT_LOW:
            begin
                dnx = dly_dec;
                if (dly_end)
                begin
                    nx.scl_drive = 1'b0;
                    nx.phase     = i2cm_pkg::PH_BIT_WAIT;
                end
            end
            i2cm_pkg::PH_BIT_WAIT:
            begin
                // Clock stretching: hold here until the slave lets SCL rise.
                if (scl_in)
                begin
                    nx.sampled = sda_in;
                    dnx        = high_ld;
                    nx.phase   = i2cm_pkg::PH_BIT_HIGH;
                end
            end
            i2cm_pkg::PH_BIT_HIGH:
            begin
                dnx = dly_dec;
                if (dly_end)
                begin
                    nx.scl_drive  = 1'b1;
                    nx.shift_byte = {st.shift_byte[6:0], st.sampled};
                    nx.bit_count  = bits_left;
                    dnx           = low_ld;
                    nx.phase      = (bits_left != 4'd0) ? i2cm_pkg::PH_BIT_LOW
                                                        : i2cm_pkg::PH_BIT_END;
                end
            end
            i2cm_pkg::PH_BIT_END:
            begin
                dnx = dly_dec;
                if (dly_end)
                begin
                    if (!st.ack_stage)
                    begin
                        // Byte finished: set up the acknowledge bit.
                        nx.rx_byte    = st.shift_byte;
                        nx.ack_stage  = 1'b1;
                        if (st.op_read)
                        begin
                            nx.shift_byte = st.nack_pending ? i2cm_pkg::BYTE_ONES
                                                            : i2cm_pkg::BYTE_ZEROS;
                            nx.sda_enable = 1'b1;
                        end
                        else
                        begin
                            nx.shift_byte = i2cm_pkg::BYTE_ONES;
                            nx.sda_enable = 1'b0;
                        end
                        nx.bit_count = i2cm_pkg::BITS_ACK;
                        dnx          = low_ld;
                        nx.phase     = i2cm_pkg::PH_BIT_LOW;
                    end
                    else
                    begin
                        if (st.op_read)
                        begin
                            nx.read_reg = st.rx_byte;
                        end
                        else
                        begin
                            nx.ack_flag = ~st.shift_byte[0];
                        end
                        nx.shift_byte = i2cm_pkg::BYTE_ONES;
                        nx.sda_enable = 1'b1;
                        nx.ack_stage  = 1'b0;
                        dn            = 1'b1;
                        nx.phase      = i2cm_pkg::PH_IDLE;
                    end
                end
            end
            default:
            begin
                nx.phase = i2cm_pkg::PH_IDLE;
            end
        endcase

        in_bit = (nx.phase == i2cm_pkg::PH_BIT_LOW)  ||
                 (nx.phase == i2cm_pkg::PH_BIT_WAIT) ||
                 (nx.phase == i2cm_pkg::PH_BIT_HIGH) ||
                 (nx.phase == i2cm_pkg::PH_BIT_END);

        // During bit transfer SDA follows the MSB of the shifter when driven.
        if (in_bit)
        begin
            nx.sda_drive = nx.sda_enable & ~nx.shift_byte[7];
        end
        else if (dn && nx.phase == i2cm_pkg::PH_IDLE && nx.bit_count == 4'd0)
        begin
            nx.sda_drive = 1'b0;
        end
    end

    assign st_next    = nx;
    assign delay_next = dnx;
    assign done       = dn;

endmodule

// ===== rtl/core/i2c_master_byte_controller.sv =====
// Top level of the I2C master byte controller: tick channel, state and result register.
//
// Usage: each transaction on the command channel (cmd_valid/cmd_ready) is one tick
// of the bus timing base. It carries a request code, the byte to write, the
// read_last flag and the sampled SCL and SDA levels. Every tick produces exactly
// one result on the result channel (res_valid/res_ready): the line drives, busy,
// a one-tick done flag, the last byte read and the acknowledge seen on the last write.
// A request code is only acted on at a tick that finds the master idle; otherwise it is ignored.
// The result of a tick is presented in the cycle after it is accepted. Throughput is
// one tick per clock cycle while res_ready stays high; the
// state registers themselves hold the result, so a stalled receiver keeps the result
// steady and cmd_ready falls until the waiting result is taken.
// Timing is set by the low and high delay registers on the write-only configuration
// port (cfg_wen, cfg_addr, cfg_wdata); write them only while the master is idle.
// Reset (rst_n low) returns the master to idle with both lines released, the timing
// registers to their defaults, and empties the result register.
module i2c_master_byte_controller #(
    parameter int unsigned DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [2:0]                        req_type,
    input  logic [7:0]                        write_data,
    input  logic                              read_last,
    input  logic                              scl_in,
    input  logic                              sda_in,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic                              scl_low,
    output logic                              sda_low,
    output logic                              busy_res,
    output logic                              done_res,
    output logic [7:0]                        read_data,
    output logic                              ack_received,
    input  logic                              cfg_wen,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    i2cm_pkg::cfg_t         cfg;
    i2cm_pkg::state_t       st_reg;
    i2cm_pkg::state_t       st_next;
    logic [DELAY_WIDTH-1:0] delay_reg;
    logic [DELAY_WIDTH-1:0] delay_next;
    logic                   done_reg;
    logic                   done_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic                   accept;

    i2cm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    i2cm_step #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_step (
        .st          (st_reg),
        .delay_count (delay_reg),
        .cfg         (cfg),
        .req_type    (req_type),
        .write_data  (write_data),
        .read_last   (read_last),
        .scl_in      (scl_in),
        .sda_in      (sda_in),
        .st_next     (st_next),
        .delay_next  (delay_next),
        .done        (done_next)
    );

    assign cmd_ready = ~res_valid_reg | res_ready;
    assign accept    = cmd_valid & cmd_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= i2cm_pkg::STATE_RST;
            delay_reg     <= '0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                st_reg    <= st_next;
                delay_reg <= delay_next;
                done_reg  <= done_next;
            end
        end
    end

    assign res_valid    = res_valid_reg;
    assign scl_low      = st_reg.scl_drive;
    assign sda_low      = st_reg.sda_drive;
    assign busy_res     = (st_reg.phase != i2cm_pkg::PH_IDLE);
    assign done_res     = done_reg;
    assign read_data    = st_reg.read_reg;
    assign ack_received = st_reg.ack_flag;

endmodule
